### src/stbs_pkg.sv
// Shared types and constants for the sorted table binary search block.
package stbs_pkg;

    localparam int TABLE_DEPTH_DEFAULT = 256;
    localparam int DATA_W              = 32;
    localparam int INDEX_W             = 8;
    localparam int COUNT_W             = 9;

    typedef enum logic
    {
        CMD_LOAD   = 1'b0,
        CMD_SEARCH = 1'b1
    } cmd_t;

    typedef struct packed
    {
        cmd_t                       cmd;
        logic [INDEX_W-1:0]         entry_index;
        logic signed [DATA_W-1:0]   entry_value;
        logic signed [DATA_W-1:0]   search_key;
    } in_item_t;

    typedef struct packed
    {
        logic                       found;
        logic [INDEX_W-1:0]         position;
    } out_item_t;

    typedef struct packed
    {
        logic [COUNT_W-1:0]         used_count;
    } cfg_item_t;

    // Commands from the controller to the datapath
    typedef struct packed
    {
        logic                       load_we;
        logic                       start;
        logic                       step;
        logic                       publish;
    } ctl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed
    {
        logic                       empty;
        logic                       done;
    } dp_status_t;

endpackage

### src/stbs_chan_if.sv
// Valid/ready channel interface carrying one payload beat.
interface stbs_chan_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### src/sorted_table_binary_search_top.sv
// Sequence: a load writes the table when it is accepted; a search is accepted, then runs
// its probes (floor(log2(n))+1 probes at most for n entries in use, one table read each, so up to
// 9 for 256 entries) and then posts the result.
// Throughput: one item at a time, set by the probe loop over the single table read port.
// Reset: clears the controller, the result valid flag and used_count; table contents
// are undefined until loaded.
module sorted_table_binary_search_top #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    stbs_chan_if.sink   cfg,
    stbs_chan_if.sink   item,
    stbs_chan_if.source result
);
    stbs_pkg::ctl_cmd_t   ctl;
    stbs_pkg::dp_status_t status;
    stbs_pkg::in_item_t   item_data;
    stbs_pkg::cfg_item_t  cfg_data;
    stbs_pkg::out_item_t  result_data;
    logic                 item_ready;
    logic                 result_valid;

    // Take register writes at any time
    assign cfg.ready   = 1'b1;
    assign cfg_data    = cfg.data;
    assign item_data   = item.data;
    assign item.ready  = item_ready;
    assign result.valid = result_valid;
    assign result.data  = result_data;

    stbs_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item.valid),
        .item_cmd     (item_data.cmd),
        .item_ready   (item_ready),
        .result_valid (result_valid),
        .result_ready (result.ready),
        .status       (status),
        .ctl          (ctl)
    );

    stbs_dp #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .status      (status),
        .cfg_we      (cfg.valid),
        .cfg_data    (cfg_data),
        .item_data   (item_data),
        .result_data (result_data)
    );
endmodule

### src/stbs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word each cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

### src/stbs_dp.sv
// Datapath: table memory, search bounds, probe compare and result registers.
module stbs_dp #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEFAULT
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  stbs_pkg::ctl_cmd_t   ctl,
    output stbs_pkg::dp_status_t status,
    input  logic                 cfg_we,
    input  stbs_pkg::cfg_item_t  cfg_data,
    input  stbs_pkg::in_item_t   item_data,
    output stbs_pkg::out_item_t  result_data
);
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    logic [stbs_pkg::COUNT_W-1:0]       used_count_reg;
    logic [CW-1:0]                      lo_reg;
    logic [CW-1:0]                      lo_next;
    logic [CW-1:0]                      hix_reg;
    logic [CW-1:0]                      hix_next;
    logic [AW-1:0]                      mid_reg;
    logic signed [stbs_pkg::DATA_W-1:0] key_reg;
    logic                               res_found_reg;
    logic [stbs_pkg::INDEX_W-1:0]       res_pos_reg;
    stbs_pkg::out_item_t                out_reg;

    logic [CW-1:0]                      count_w;
    logic [CW-1:0]                      mid_w;
    logic [CW-1:0]                      span_w;
    logic [AW-1:0]                      mid0;
    logic [AW-1:0]                      mid_step;
    logic [AW-1:0]                      raddr;
    logic [stbs_pkg::DATA_W-1:0]        rdata;
    logic                               wr_en;
    logic                               hit;
    logic                               below;

    // Saturate the entry count to the table depth
    always_comb
    begin
        if (32'(used_count_reg) > 32'(TABLE_DEPTH))
        begin
            count_w = CW'(TABLE_DEPTH);
        end
        else
        begin
            count_w = CW'(used_count_reg);
        end
    end

    // Compare the probed entry and narrow the bounds
    always_comb
    begin
        mid_w    = CW'(mid_reg);
        hit      = ($signed(rdata) == key_reg);
        below    = ($signed(rdata) < key_reg);
        lo_next  = lo_reg;
        hix_next = hix_reg;
        if (below)
        begin
            lo_next = mid_w + CW'(1);
        end
        else
        begin
            hix_next = mid_w;
        end
        span_w   = hix_next - lo_next - CW'(1);
        mid_step = AW'(lo_next + (span_w >> 1));
        mid0     = AW'((count_w - CW'(1)) >> 1);
    end

    assign status.empty = (count_w == '0);
    assign status.done  = hit || (lo_next >= hix_next);

    // Table port: loads write, probes read the next midpoint
    assign wr_en = ctl.load_we && (32'(item_data.entry_index) < 32'(TABLE_DEPTH));
    assign raddr = ctl.start ? mid0 : mid_step;

    stbs_ram #(
        .WIDTH (stbs_pkg::DATA_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (AW'(item_data.entry_index)),
        .wdata (item_data.entry_value),
        .raddr (raddr),
        .rdata (rdata)
    );

    // Hold the entry count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_count_reg <= '0;
        end
        else if (cfg_we)
        begin
            used_count_reg <= cfg_data.used_count;
        end
    end

    // Advance search state and capture results
    always_ff @(posedge clk)
    begin
        if (ctl.start)
        begin
            lo_reg        <= '0;
            hix_reg       <= count_w;
            mid_reg       <= mid0;
            key_reg       <= item_data.search_key;
            res_found_reg <= 1'b0;
            res_pos_reg   <= '0;
        end
        else if (ctl.step)
        begin
            lo_reg  <= lo_next;
            hix_reg <= hix_next;
            mid_reg <= mid_step;
            if (status.done)
            begin
                res_found_reg <= hit;
                res_pos_reg   <= hit ? stbs_pkg::INDEX_W'(mid_reg) : '0;
            end
        end
        if (ctl.publish)
        begin
            out_reg.found    <= res_found_reg;
            out_reg.position <= res_pos_reg;
        end
    end

    assign result_data = out_reg;

    // The range stays open while the search goes on
    a_range_open: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.step && !status.done) |=> (lo_reg < hix_reg))
        else $error("search range closed without done");

    // A started search on a filled table has a nonzero upper bound
    a_start_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.start && !status.empty) |=> (hix_reg != '0))
        else $error("search started with empty range");
endmodule

### src/stbs_ctrl.sv
// Controller: handshakes, search sequencing and the result valid flag.
module stbs_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  stbs_pkg::cmd_t       item_cmd,
    output logic                 item_ready,
    output logic                 result_valid,
    input  logic                 result_ready,
    input  stbs_pkg::dp_status_t status,
    output stbs_pkg::ctl_cmd_t   ctl
);
    typedef enum logic [1:0]
    {
        ST_IDLE,
        ST_SEARCH,
        ST_POST
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   result_valid_reg;
    logic   result_valid_next;
    logic   accept;

    // Sequence one item at a time
    always_comb
    begin
        item_ready        = (state_reg == ST_IDLE);
        accept            = item_valid && item_ready;
        ctl               = '0;
        state_next        = state_reg;
        result_valid_next = result_valid_reg && !result_ready;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (item_cmd == stbs_pkg::CMD_SEARCH)
                    begin
                        ctl.start  = 1'b1;
                        state_next = status.empty ? ST_POST : ST_SEARCH;
                    end
                    else
                    begin
                        ctl.load_we = 1'b1;
                    end
                end
            end
            ST_SEARCH:
            begin
                ctl.step = 1'b1;
                if (status.done)
                begin
                    state_next = ST_POST;
                end
            end
            ST_POST:
            begin
                if (!result_valid_reg || result_ready)
                begin
                    ctl.publish       = 1'b1;
                    result_valid_next = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            result_valid_reg <= result_valid_next;
        end
    end

    assign result_valid = result_valid_reg;

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.publish |-> (!result_valid_reg || result_ready))
        else $error("result overwritten while pending");

    // At most one datapath command per cycle
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0({ctl.load_we, ctl.start, ctl.step, ctl.publish}))
        else $error("conflicting datapath commands");

    // A search on a filled table goes to probing
    a_start_probe: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.start && !status.empty) |=> (state_reg == ST_SEARCH))
        else $error("search did not enter probing");
endmodule
